// ===== src/mavg_pkg.sv =====
`timescale 1ns / 1ps

package mavg_pkg;

  // Width and reset value of the window_length register
  localparam int unsigned WIN_W = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd8;

  // Controller to datapath
  typedef struct packed {
    logic load;      // write sample, advance ring, start summing
    logic rd_step;   // read and accumulate one held entry
    logic div_init;  // latch magnitude and sign of the sum
    logic div_step;  // one quotient bit
    logic out_load;  // place the quotient in the output register
  } mavg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic out_busy;
  } mavg_sts_t;

endpackage

// ===== src/mavg_if.sv =====
`timescale 1ns / 1ps

interface mavg_sample_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mavg_average_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

interface mavg_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

// ===== src/mavg_dp.sv =====
`timescale 1ns / 1ps

module mavg_dp
  import mavg_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mavg_cmd_t                     cmd_i,
  output mavg_sts_t                     sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          win_we_i,
  input  logic [WIN_W-1:0]              win_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] average_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LIM_W  = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  logic [SAMPLE_BITS-1:0]        mem_q [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]        rdata_q;
  logic                          rd_vld_q;
  logic [PTR_W-1:0]              wp_q, rd_ptr_q;
  logic [CNT_W-1:0]              held_q, held_d, rem_cnt_q;
  logic [WIN_W-1:0]              win_q;
  logic signed [SUM_W-1:0]       acc_q;
  logic [SUM_W-1:0]              quo_q, quo_d, acc_mag;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [CNT_W:0]                shifted;
  logic                          neg_q, quo_bit;
  logic [DCNT_W-1:0]             div_cnt_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] average_q, avg_d;
  logic [SAMPLE_BITS-1:0]        quo_low;
  logic [LIM_W-1:0]              limit, held_plus;

  // Clamp window to storage depth, then grow held count by one, capped at that limit
  always_comb begin
    limit = (LIM_W'(win_q) > LIM_W'(MAX_WINDOW)) ? LIM_W'(MAX_WINDOW) : LIM_W'(win_q);
    held_plus = LIM_W'(held_q) + LIM_W'(1);
    held_d = (held_plus > limit) ? CNT_W'(limit) : CNT_W'(held_plus);
  end

  // Restoring division step on the magnitude of the sum
  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    quo_bit = (shifted >= {1'b0, held_q});
    rem_d   = quo_bit ? CNT_W'(shifted - {1'b0, held_q}) : shifted[CNT_W-1:0];
    quo_d   = {quo_q[SUM_W-2:0], quo_bit};
    acc_mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
    quo_low = quo_q[SAMPLE_BITS-1:0];
    if (held_q == '0) begin
      avg_d = '0;
    end else if (neg_q) begin
      avg_d = signed'(SAMPLE_BITS'(-quo_low));
    end else begin
      avg_d = signed'(quo_low);
    end
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[wp_q] <= sample_i;
    end
    if (cmd_i.rd_step && rem_cnt_q != '0) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      held_q      <= '0;
      win_q       <= WIN_RESET;
      rd_ptr_q    <= '0;
      rem_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      acc_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (win_we_i) begin
        win_q <= win_data_i;
      end
      if (cmd_i.load) begin
        wp_q      <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
        held_q    <= held_d;
        rd_ptr_q  <= wp_q;
        rem_cnt_q <= held_d;
        rd_vld_q  <= 1'b0;
        acc_q     <= '0;
      end else if (cmd_i.rd_step) begin
        if (rem_cnt_q != '0) begin
          rd_ptr_q  <= (rd_ptr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr_q - PTR_W'(1);
          rem_cnt_q <= rem_cnt_q - CNT_W'(1);
          rd_vld_q  <= 1'b1;
        end else begin
          rd_vld_q <= 1'b0;
        end
        if (rd_vld_q) begin
          acc_q <= acc_q + {{(SUM_W - SAMPLE_BITS){rdata_q[SAMPLE_BITS-1]}}, rdata_q};
        end
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= DCNT_W'(SUM_W);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Division and output payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= acc_q[SUM_W-1];
      quo_q <= acc_mag;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      average_q <= avg_d;
    end
  end

  assign sts_o.sum_done = (rem_cnt_q == '0) && !rd_vld_q;
  assign sts_o.div_done = (div_cnt_q == '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign average_o      = average_q;

  held_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(MAX_WINDOW))
    else $error("held count exceeds store depth");

  rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step && held_q != '0 |=> rem_q < held_q)
    else $error("division remainder not below divisor");

  load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result lost at output register");

endmodule

// ===== src/mavg_ctrl.sv =====
`timescale 1ns / 1ps

module mavg_ctrl
  import mavg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mavg_sts_t sts_i,
  output mavg_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i && in_ready_q;
      end
      S_READ: begin
        cmd_o.rd_step  = 1'b1;
        cmd_o.div_init = sts_i.sum_done;
      end
      S_DIV: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.out_load = sts_i.div_done && !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_READ;
            in_ready_q <= 1'b0;
          end
        end
        S_READ: begin
          if (sts_i.sum_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (sts_i.div_done && !sts_i.out_busy) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

  load_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_READ && !in_ready_q)
    else $error("accepted sample did not start a sum");

endmodule

// ===== src/moving_average_filter.sv =====
`timescale 1ns / 1ps

// Channel   Modport  Payload                    Transfer when
// smp_if    sink     sample [SAMPLE_BITS]       valid && ready
// avg_if    source   average [SAMPLE_BITS]      valid && ready
// cfg_if    sink     window_length [7]          valid && ready (ready tied high)
//
// Each transfer on smp_if yields one transfer on avg_if, in order.
// Throughput is set by the single read port of the sample store (one entry
// a cycle) and the one-bit-a-cycle divider; no new sample is taken until
// the result for the last one has gone into the output register.
// Reset clears ring position and held count; window_length returns to 8.
// A stalled result sits in the output register while the next sample is
// taken; only the final divide-to-output step waits on a free output slot.

module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mavg_sample_if.sink    smp_if,
  mavg_average_if.source avg_if,
  mavg_cfg_if.sink       cfg_if
);

  mavg_cmd_t cmd;
  mavg_sts_t sts;

  // Configuration writes land directly in the window register
  assign cfg_if.ready = 1'b1;

  // Sequencer: accept, sweep the held entries, divide, hand off
  mavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_if.valid),
    .in_ready_o (smp_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring store, accumulator, serial divider and output register
  mavg_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (smp_if.sample),
    .win_we_i    (cfg_if.valid),
    .win_data_i  (cfg_if.window_length),
    .out_ready_i (avg_if.ready),
    .out_valid_o (avg_if.valid),
    .average_o   (avg_if.average)
  );

endmodule
